// File: rtl/afce_pkg.sv
// afce_pkg: shared types and constants for the adc frame channel extractor
// used by afce_parser, afce_scale and adc_frame_channel_extract; no dependencies
`timescale 1ns / 1ps

package afce_pkg;

  typedef enum logic [1:0] {
    PH_HUNT    = 2'd0,
    PH_HEADER  = 2'd1,
    PH_COUNT   = 2'd2,
    PH_PAYLOAD = 2'd3
  } phase_e;

  // configuration register indexes
  localparam logic REG_CHANNEL_ID = 1'b0;
  localparam logic REG_MAX_BYTES  = 1'b1;

  localparam logic [7:0]  CHANNEL_ID_RESET = 8'hEA;
  localparam logic [11:0] MAX_BYTES_RESET  = 12'd1500;

  localparam logic [31:0] SYNC_WORD = 32'hFFFF_FFFF;

  localparam int SAMPLE_W = 24;
  localparam int VOLTS_W  = 21;
  localparam int LEFT_W   = 10;

  // volts = sample * 1024 / 9375, done as a reciprocal multiply:
  // q = (|s| * ceil(2^46 / 9375)) >> 36 is exact for |s| <= 2^23
  localparam int          VOLT_DIV   = 9375;
  localparam int          VOLT_SHIFT = 36;
  localparam int          MULT_SPLIT = 17;
  localparam logic [32:0] VOLT_MULT  =
    33'(((64'd1 << 46) + 64'(VOLT_DIV) - 64'd1) / 64'(VOLT_DIV));
  localparam logic [15:0] VOLT_MULT_HI = 16'(VOLT_MULT >> MULT_SPLIT);
  localparam logic [16:0] VOLT_MULT_LO = VOLT_MULT[16:0];

  typedef struct packed {
    logic [7:0]  channel_id;
    logic [11:0] max_frame_bytes;
  } cfg_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] top_max;
    logic [SAMPLE_W-1:0] next_max;
    logic [SAMPLE_W-1:0] top_min;
    logic [SAMPLE_W-1:0] next_min;
  } extremes_t;

endpackage

// File: rtl/adc_frame_channel_extract.sv
// adc_frame_channel_extract: top level, apb registers and pipeline control
// depends on afce_pkg, afce_parser, afce_scale
`timescale 1ns / 1ps
//
// Usage:
// - input channel (in_valid_i/in_ready_o) carries one 32-bit stream word or a
//   clear action per transfer; the parser hunts for the all-ones sync word,
//   checks header and byte count, then walks the payload words
// - a payload word tagged with channel_id yields one result on the output
//   channel (out_valid_o/out_ready_i); all other words yield nothing
// - a result passes through the parse stage, the multiply stage and the output
//   register in that order before it is valid on the output channel
// - throughput: one word per cycle; the three stages each hold one item and
//   move whenever the next one is free, so a stalled receiver fills them and
//   then drops in_ready_o
// - the apb port holds channel_id (0x0) and max_frame_bytes (0x4); pready is
//   tied high, write only while the block is idle
// - reset: parser hunting, extremes zero, pipeline empty, registers at
//   channel_id 0xEA and max_frame_bytes 1500
//
module adc_frame_channel_extract (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                action_i,
  input  logic [31:0]         data_word_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic signed [23:0]  sample_raw_o,
  output logic signed [20:0]  sample_volts_q16_o,
  output logic [22:0]         max_first_o,
  output logic [22:0]         max_second_o,
  output logic signed [23:0]  min_first_o,
  output logic signed [23:0]  min_second_o
);
  import afce_pkg::*;

  cfg_t      cfg_q;
  logic      cfg_wr;

  logic      take, hit;
  logic signed [SAMPLE_W-1:0] p_sample;
  extremes_t p_ext;

  logic      v1_q, v2_q, vo_q;
  logic signed [SAMPLE_W-1:0] s1_q, s2_q, so_q;
  extremes_t ext1_q, ext2_q, exto_q;
  logic      o_free, adv1, adv2, r1, r2;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.channel_id      <= CHANNEL_ID_RESET;
      cfg_q.max_frame_bytes <= MAX_BYTES_RESET;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_CHANNEL_ID: cfg_q.channel_id      <= pwdata[7:0];
        REG_MAX_BYTES:  cfg_q.max_frame_bytes <= pwdata[11:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_CHANNEL_ID: prdata = {24'd0, cfg_q.channel_id};
      REG_MAX_BYTES:  prdata = {20'd0, cfg_q.max_frame_bytes};
      default:        prdata = '0;
    endcase
  end

  // stage handshake, each stage moves when the one after it is free
  assign o_free     = !vo_q || out_ready_i;
  assign adv2       = v2_q && o_free;
  assign r2         = !v2_q || o_free;
  assign adv1       = v1_q && r2;
  assign r1         = !v1_q || r2;
  assign in_ready_o = r1;
  assign take       = in_valid_i && r1;

  afce_parser u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .take_i   (take),
    .action_i (action_i),
    .word_i   (data_word_i),
    .cfg_i    (cfg_q),
    .hit_o    (hit),
    .sample_o (p_sample),
    .ext_o    (p_ext)
  );

  afce_scale u_scale (
    .clk_i    (clk_i),
    .load_a_i (adv1),
    .load_b_i (adv2),
    .sample_i (s1_q),
    .volts_o  (sample_volts_q16_o)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (take && hit)  v1_q <= 1'b1;
      else if (adv1)    v1_q <= 1'b0;
      if (adv1)         v2_q <= 1'b1;
      else if (adv2)    v2_q <= 1'b0;
      if (adv2)         vo_q <= 1'b1;
      else if (out_ready_i) vo_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && hit) begin
      s1_q   <= p_sample;
      ext1_q <= p_ext;
    end
    if (adv1) begin
      s2_q   <= s1_q;
      ext2_q <= ext1_q;
    end
    if (adv2) begin
      so_q   <= s2_q;
      exto_q <= ext2_q;
    end
  end

  assign out_valid_o  = vo_q;
  assign sample_raw_o = so_q;
  assign max_first_o  = exto_q.top_max[22:0];
  assign max_second_o = exto_q.next_max[22:0];
  assign min_first_o  = $signed(exto_q.top_min);
  assign min_second_o = $signed(exto_q.next_min);

  // distinct top-two ordering holds for every delivered result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (max_second_o < max_first_o || max_second_o == 23'd0))
    else $error("max_second not below max_first");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (min_second_o > min_first_o || min_second_o == 24'sd0))
    else $error("min_second not above min_first");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && sample_raw_o >= 0) |-> sample_volts_q16_o >= 0)
    else $error("volts sign disagrees with sample");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v2_q && !o_free) |=> (v2_q && $stable(s2_q)))
    else $error("middle stage lost its item under stall");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input blocked with empty output register");

endmodule

// File: rtl/afce_parser.sv
// afce_parser: frame hunt / header / count / payload walk and running extremes
// depends on afce_pkg
`timescale 1ns / 1ps

module afce_parser (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          take_i,
  input  logic                          action_i,
  input  logic [31:0]                   word_i,
  input  afce_pkg::cfg_t                cfg_i,
  output logic                          hit_o,
  output logic signed [afce_pkg::SAMPLE_W-1:0] sample_o,
  output afce_pkg::extremes_t           ext_o
);
  import afce_pkg::*;

  phase_e              phase_q, phase_d;
  logic [LEFT_W-1:0]   left_q, left_d;
  extremes_t           ext_q, ext_d;
  logic signed [SAMPLE_W-1:0] s;
  logic                oversize;

  assign s        = $signed(word_i[SAMPLE_W-1:0]);
  assign oversize = (word_i[31:12] != 20'd0) || (word_i[11:0] > cfg_i.max_frame_bytes);

  always_comb begin
    phase_d = phase_q;
    left_d  = left_q;
    ext_d   = ext_q;
    hit_o   = 1'b0;
    if (take_i) begin
      if (action_i) begin
        phase_d = PH_HUNT;
        left_d  = '0;
        ext_d   = '0;
      end else begin
        case (phase_q)
          PH_HUNT: begin
            if (word_i == SYNC_WORD) phase_d = PH_HEADER;
          end
          PH_HEADER: begin
            phase_d = word_i[31] ? PH_HUNT : PH_COUNT;
          end
          PH_COUNT: begin
            if (oversize) begin
              phase_d = PH_HUNT;
            end else begin
              left_d  = word_i[LEFT_W+1:2];
              phase_d = (word_i[LEFT_W+1:2] == '0) ? PH_HUNT : PH_PAYLOAD;
            end
          end
          PH_PAYLOAD: begin
            left_d = left_q - LEFT_W'(1);
            if (left_d == '0) phase_d = PH_HUNT;
            if (word_i[31:24] == cfg_i.channel_id) begin
              hit_o = 1'b1;
              // keep the two largest distinct positives and two smallest negatives
              if (s > 0) begin
                if (s > $signed(ext_q.top_max)) begin
                  ext_d.next_max = ext_q.top_max;
                  ext_d.top_max  = s;
                end else if (s < $signed(ext_q.top_max) && s > $signed(ext_q.next_max)) begin
                  ext_d.next_max = s;
                end
              end else if (s < 0) begin
                if (s < $signed(ext_q.top_min)) begin
                  ext_d.next_min = ext_q.top_min;
                  ext_d.top_min  = s;
                end else if (s > $signed(ext_q.top_min) && s < $signed(ext_q.next_min)) begin
                  ext_d.next_min = s;
                end
              end
            end
          end
          default: phase_d = PH_HUNT;
        endcase
      end
    end
  end

  assign sample_o = s;
  assign ext_o    = ext_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT;
      left_q  <= '0;
      ext_q   <= '0;
    end else begin
      phase_q <= phase_d;
      left_q  <= left_d;
      ext_q   <= ext_d;
    end
  end

endmodule

// File: rtl/afce_scale.sv
// afce_scale: two-stage sample to q16 volts conversion, split reciprocal multiply
// depends on afce_pkg
`timescale 1ns / 1ps

module afce_scale (
  input  logic                                  clk_i,
  input  logic                                  load_a_i,
  input  logic                                  load_b_i,
  input  logic signed [afce_pkg::SAMPLE_W-1:0]  sample_i,
  output logic signed [afce_pkg::VOLTS_W-1:0]   volts_o
);
  import afce_pkg::*;

  localparam int HI_W  = SAMPLE_W + 16;
  localparam int LO_W  = SAMPLE_W + 17;
  localparam int SUM_W = SAMPLE_W + 33;

  logic [SAMPLE_W-1:0] mag;
  logic [HI_W-1:0]     p_hi_q;
  logic [LO_W-1:0]     p_lo_q;
  logic                neg_q;
  logic [SUM_W-1:0]    sum;
  logic [VOLTS_W-1:0]  quot;
  logic [VOLTS_W-1:0]  volts_q;

  // magnitude fits 24 bits unsigned, including the most negative code
  assign mag = sample_i[SAMPLE_W-1] ? SAMPLE_W'(-sample_i) : SAMPLE_W'(sample_i);

  always_ff @(posedge clk_i) begin
    if (load_a_i) begin
      p_hi_q <= HI_W'(mag) * HI_W'(VOLT_MULT_HI);
      p_lo_q <= LO_W'(mag) * LO_W'(VOLT_MULT_LO);
      neg_q  <= sample_i[SAMPLE_W-1];
    end
  end

  assign sum  = (SUM_W'(p_hi_q) << MULT_SPLIT) + SUM_W'(p_lo_q);
  assign quot = sum[VOLT_SHIFT+VOLTS_W-1:VOLT_SHIFT];

  // truncation toward zero: negate the magnitude quotient
  always_ff @(posedge clk_i) begin
    if (load_b_i) begin
      volts_q <= neg_q ? (~quot + VOLTS_W'(1)) : quot;
    end
  end

  assign volts_o = $signed(volts_q);

endmodule
